// ===== src/ovl_pkg.sv =====
// Shared constants, codes, types and helpers for the ordered value list.
package ovl_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VAL_W   = 32;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd2;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               empty_res;
        logic               overflow;
        logic               found;
    } ovl_res_t;

    // The reported count is the entry count masked to the field width.
    function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+COUNT_W-1:0] w;
        w = {{COUNT_W{1'b0}}, c};
        return w[COUNT_W-1:0];
    endfunction

endpackage

// ===== src/ordered_value_list_unit.sv =====
// Top level of the ordered value list: RAM, sequencer and output register.
// Append writes the value at the end of the list; check and delete scan the
// entries in order from the oldest until the first match, and delete then
// moves each later entry down one place.
// The sequencer takes a new request only after the result of the last one
// has moved on into the output register.
// Reset clears the entry count and control state; RAM contents stay undefined.
module ordered_value_list_unit
    import ovl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // found[0], overflow[1], empty_res[2], count[7:3]
);

    logic              res_valid;
    logic              res_take;
    ovl_res_t          res;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;
    logic              out_valid_reg, out_valid_next;
    ovl_res_t          out_data_reg, out_data_next;

    ovl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_kind  (s_tuser),
        .req_value (s_tdata),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ovl_ram #(
        .DATA_W (VAL_W),
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A finished result moves into the output register once it is free.
    assign res_take = res_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.count, out_data_reg.empty_res,
                       out_data_reg.overflow, out_data_reg.found};

endmodule

// ===== src/ovl_ram.sv =====
// Simple dual-port synchronous RAM with one registered read port.
module ovl_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4,
    parameter int DEPTH  = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/ovl_ctrl.sv =====
// Sequencer that scans, appends to and compacts the list held in RAM.
module ovl_ctrl
    import ovl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [KIND_W-1:0]  req_kind,
    input  logic [VAL_W-1:0]   req_value,
    output logic               res_valid,
    input  logic               res_take,
    output ovl_res_t           res,
    output logic               ram_we,
    output logic [ADDR_W-1:0]  ram_waddr,
    output logic [VAL_W-1:0]   ram_wdata,
    output logic               ram_re,
    output logic [ADDR_W-1:0]  ram_raddr,
    input  logic [VAL_W-1:0]   ram_rdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              found_reg, found_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  idx_p1;
    logic [CNT_W-1:0]  idx_p2;

    assign idx_p1 = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_p2 = CNT_W'(idx_reg) + CNT_W'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        ovf_reg   <= ovf_next;
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        ovf_next   = ovf_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = value_reg;
        ram_re     = 1'b0;
        ram_raddr  = idx_p1[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = req_kind;
                    value_next = req_value;
                    found_next = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                unique case (kind_reg)
                    KIND_APPEND:
                    begin
                        if (cnt_reg < CNT_W'(DEPTH))
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cnt_reg[ADDR_W-1:0];
                            cnt_next  = cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    KIND_DELETE, KIND_CHECK:
                    begin
                        if (cnt_reg == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                // Read data belongs to entry idx_reg; the next entry is fetched meanwhile.
                if (ram_rdata == value_reg)
                begin
                    found_next = 1'b1;
                    if (kind_reg == KIND_CHECK)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (idx_p1 == cnt_reg)
                    begin
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = ST_SHIFT;
                    end
                end
                else if (idx_p1 == cnt_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_re   = 1'b1;
                    idx_next = idx_p1[ADDR_W-1:0];
                end
            end
            ST_SHIFT:
            begin
                // Entry idx_reg + 1 arrives and moves down one place.
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (idx_p2 == cnt_reg)
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_p2[ADDR_W-1:0];
                    idx_next  = idx_p1[ADDR_W-1:0];
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_ready     = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_DONE);
    assign res.found     = found_reg;
    assign res.overflow  = ovf_reg;
    assign res.empty_res = (cnt_reg == '0);
    assign res.count     = count_field(cnt_reg);

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && ovf_reg) |-> (cnt_reg == CNT_W'(DEPTH) && !found_reg))
        else $error("overflow reported while list not full");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (idx_p1 < cnt_reg && kind_reg == KIND_DELETE))
        else $error("compaction outside the live entries");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write to the same entry in one cycle");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the ordered value list unit.
`timescale 1ns / 1ps

module tb
    import ovl_pkg::*;
();

    localparam time HALF_PERIOD    = 5ns;
    localparam int  RESET_CYCLES   = 5;
    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  DRAIN_CYCLES   = 2 * DEPTH + 8;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [VAL_W-1:0] VALUE_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VALUE_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] VALUE_ALL = 32'hffff_ffff;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;   // value[31:0]
    logic [1:0]        s_tuser;   // kind[1:0]
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;   // found[0], overflow[1], empty_res[2], count[7:3]

    // Mirror of the list contents, oldest entry first.
    logic [VAL_W-1:0]  list_mirror[$];
    ovl_res_t          pending_results[$];

    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int mismatch_count    = 0;
    int requests_sent     = 0;
    int appends_dropped   = 0;
    int deletes_matched   = 0;
    int peak_fill         = 0;
    int quiet_cycles      = 0;

    ordered_value_list_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Applies one request to the mirror and returns the result it must produce.
    function automatic ovl_res_t apply_list_request(input logic [KIND_W-1:0] kind,
                                                    input logic [VAL_W-1:0] value);
        ovl_res_t res;
        int       hit;
        res = '0;
        hit = -1;
        for (int i = 0; i < list_mirror.size(); i++)
        begin
            if (hit < 0 && list_mirror[i] == value)
                hit = i;
        end
        case (kind)
            KIND_APPEND:
            begin
                if (list_mirror.size() < DEPTH)
                    list_mirror.push_back(value);
                else
                    res.overflow = 1'b1;
            end
            KIND_DELETE:
            begin
                if (hit >= 0)
                begin
                    res.found = 1'b1;
                    list_mirror.delete(hit);
                end
            end
            KIND_CHECK:
                res.found = (hit >= 0);
            default:
                ;
        endcase
        res.empty_res = (list_mirror.size() == 0);
        res.count     = COUNT_W'(list_mirror.size());
        return res;
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] value);
        ovl_res_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_list_request(kind, value);
        pending_results.push_back(predicted);
        requests_sent++;
        if (predicted.overflow)
            appends_dropped++;
        if (kind == KIND_DELETE && predicted.found)
            deletes_matched++;
        if (list_mirror.size() > peak_fill)
            peak_fill = list_mirror.size();
    endtask

    function automatic void compare_field(input string name, input logic [COUNT_W-1:0] wanted,
                                          input logic [COUNT_W-1:0] seen);
        if (wanted !== seen)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, wanted, seen);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        ovl_res_t seen;
        ovl_res_t wanted;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = m_tdata;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result %h arrived with nothing expected", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                wanted = pending_results.pop_front();
                compare_field("found", COUNT_W'(wanted.found), COUNT_W'(seen.found));
                compare_field("overflow", COUNT_W'(wanted.overflow), COUNT_W'(seen.overflow));
                compare_field("empty_res", COUNT_W'(wanted.empty_res),
                              COUNT_W'(seen.empty_res));
                compare_field("count", wanted.count, seen.count);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    task automatic test_empty_list;
        send_request(KIND_CHECK, '0);
        send_request(KIND_UNUSED, VALUE_ALL);
    endtask

    // The first delete of 42 must take the older copy; the second copy stays.
    task automatic test_duplicates_and_misses;
        send_request(KIND_APPEND, VALUE_MIN);
        send_request(KIND_APPEND, 32'd42);
        send_request(KIND_APPEND, VALUE_MAX);
        send_request(KIND_APPEND, 32'd42);
        send_request(KIND_DELETE, 32'd42);
        send_request(KIND_CHECK, 32'd42);
        send_request(KIND_DELETE, 32'd7);
        send_request(KIND_DELETE, VALUE_MIN);
    endtask

    task automatic test_full_list;
        int n;
        n = 0;
        while (list_mirror.size() < DEPTH)
        begin
            send_request(KIND_APPEND, (n % 2 == 0) ? '0 : VALUE_ALL - n);
            n++;
        end
        send_request(KIND_APPEND, VALUE_MAX);
        send_request(KIND_CHECK, VALUE_MAX);
        send_request(KIND_DELETE, 32'd42);
        send_request(KIND_DELETE, list_mirror[list_mirror.size() - 1]);
    endtask

    function automatic logic [VAL_W-1:0] pool_value(input int idx);
        case (idx)
            0: return '0;
            1: return VALUE_ALL;
            2: return VALUE_MIN;
            3: return VALUE_MAX;
            4: return 32'd1;
            5: return 32'h5555_5555;
            6: return 32'haaaa_aaaa;
            default: return 32'd42;
        endcase
    endfunction

    // Alternates windows that mostly grow the list with windows that mostly
    // shrink it, so the fill level sweeps between empty and full.
    task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  value;
        int                roll;
        int                window;
        bit                growing;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        growing = 1'b1;
        window  = $urandom_range(10, 30);
        for (int i = 0; i < n_items; i++)
        begin
            if (window == 0)
            begin
                growing = !growing;
                window  = $urandom_range(10, 30);
            end
            window--;
            roll = $urandom_range(0, 99);
            if (roll >= 95)
                kind = KIND_UNUSED;
            else if (roll < (growing ? 60 : 20))
                kind = KIND_APPEND;
            else if (roll < (growing ? 78 : 70))
                kind = KIND_DELETE;
            else
                kind = KIND_CHECK;
            roll = $urandom_range(0, 99);
            if (kind != KIND_APPEND && list_mirror.size() > 0 && roll < 70)
                value = list_mirror[$urandom_range(0, list_mirror.size() - 1)];
            else if (roll < 85)
                value = pool_value($urandom_range(0, 7));
            else
                value = $urandom();
            send_request(kind, value);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_APPEND;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_duplicates_and_misses();
        test_full_list();
        test_random_traffic(130, 0, 0);
        test_random_traffic(130, 53, 0);
        test_random_traffic(130, 0, 53);
        test_random_traffic(130, 24, 24);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests over four idling phases, peak fill %0d of %0d.",
                 requests_sent, peak_fill, DEPTH);
        $display("Appends dropped on a full list: %0d, deletes that matched: %0d.",
                 appends_dropped, deletes_matched);
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ovl_pkg.sv
src/ovl_ram.sv
src/ovl_ctrl.sv
src/ordered_value_list_unit.sv
tb/sv/tb.sv
